FILE: design/lla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_pkg
// Shared constants and types of the life-like automaton row step.
// ----------------------------------------------------------------------------
package lla_pkg;

	localparam int GRID_COLS = 64;
	localparam int ROW_W     = 64;
	localparam int CNT_W     = 4;
	localparam int SUM_W     = 2;
	localparam int BEAT_W    = ROW_W + 1;

	localparam logic [3:0] BIRTH_RESET   = 4'd3;
	localparam logic [3:0] SURVIVE_RESET = 4'd2;

	localparam logic REG_BIRTH   = 1'b0;
	localparam logic REG_SURVIVE = 1'b1;

	typedef struct packed {
		logic use_in_mid;   // current input row stands in as the middle row
		logic use_in_down;  // current input row is the row below
		logic advance;      // above <= middle, middle <= input
		logic clear;        // return to the dead border
	} cell_ctrl_t;

	typedef struct packed {
		logic [3:0] birth;
		logic [3:0] survive;
	} rule_t;

endpackage

FILE: design/lla_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_cell
// One grid column: holds the above and middle bits, hands its column sum to
// both neighbors and applies the birth / survive rule.
// ----------------------------------------------------------------------------
module lla_cell
	import lla_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  rule_t            rule,
	input  logic             row_bit,
	input  logic [SUM_W-1:0] left_sum,
	input  logic [SUM_W-1:0] right_sum,
	output logic [SUM_W-1:0] col_sum,
	output logic             next_bit
);

	logic             above_q;
	logic             mid_q;
	logic             mid_eff;
	logic             down_eff;
	logic [CNT_W-1:0] cnt;

	assign mid_eff  = ctrl.use_in_mid ? row_bit : mid_q;
	assign down_eff = ctrl.use_in_down & row_bit;
	assign col_sum  = SUM_W'(above_q) + SUM_W'(mid_eff) + SUM_W'(down_eff);

	// eight-neighbor count: three columns minus the cell itself
	assign cnt = CNT_W'(left_sum) + CNT_W'(col_sum) + CNT_W'(right_sum)
		- CNT_W'(mid_eff);

	always_comb begin
		priority if (cnt == rule.birth) begin
			next_bit = 1'b1;
		end else if (cnt == rule.survive) begin
			next_bit = mid_eff;
		end else begin
			next_bit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
			mid_q   <= 1'b0;
		end else if (ctrl.clear) begin
			above_q <= 1'b0;
			mid_q   <= 1'b0;
		end else if (ctrl.advance) begin
			above_q <= mid_q;
			mid_q   <= row_bit;
		end
	end

endmodule

FILE: design/lla_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lla_out_fifo
// Two-entry result queue between the cell row and the output stream.
// ----------------------------------------------------------------------------
module lla_out_fifo
	import lla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [BEAT_W-1:0] push_data,
	input  logic              pop,
	output logic              not_full,
	output logic              not_empty,
	output logic [BEAT_W-1:0] head,
	output logic [1:0]        count
);

	logic [BEAT_W-1:0] mem_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        count_q;
	logic              do_pop;

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign do_pop    = pop & not_empty;
	assign head      = mem_q[rd_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

FILE: design/life_like_automaton_row_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_row_step
// One generation of a life-like automaton, streamed one grid row per beat.
// A result row is queued as the row below it is taken, one row per cycle while
// the queue has room; a final row that flushes two results adds a flush step,
// in which the cell row computes the bottom row alone. Reset: asynchronous,
// active low; rules return to birth 3 / survive 2, held rows to dead border.
// ----------------------------------------------------------------------------
module life_like_automaton_row_step
	import lla_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// config port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input rows
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [ROW_W-1:0] s_tdata,   // [63:0] row_cells
	input  logic             s_tlast,   // final_row
	// result rows
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [ROW_W-1:0] m_tdata,   // [63:0] next_row_cells
	output logic             m_tlast    // frame_end
);

	// ------------------------------------------------------------------
	// Rule registers
	// ------------------------------------------------------------------
	rule_t rule_q;
	logic  cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q.birth   <= BIRTH_RESET;
			rule_q.survive <= SURVIVE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BIRTH:   rule_q.birth   <= pwdata[3:0];
				REG_SURVIVE: rule_q.survive <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BIRTH:   prdata = {28'd0, rule_q.birth};
			REG_SURVIVE: prdata = {28'd0, rule_q.survive};
		endcase
	end

	// ------------------------------------------------------------------
	// Row sequencing
	// mid_valid_q : a middle row is held and waits for the row below
	// flush_q     : bottom row still to be computed against the dead border
	// ------------------------------------------------------------------
	logic       mid_valid_q;
	logic       flush_q;
	logic       room;
	logic       in_beat;
	logic       push;
	logic       push_last;
	logic [1:0] fifo_count;
	cell_ctrl_t ctrl;

	assign s_tready = room & ~flush_q;
	assign in_beat  = s_tvalid & s_tready;

	always_comb begin
		ctrl      = '0;
		push      = 1'b0;
		push_last = 1'b0;
		if (flush_q) begin
			// above = old middle, middle = last row, below = border
			push       = room;
			push_last  = 1'b1;
			ctrl.clear = room;
		end else if (in_beat) begin
			ctrl.use_in_down = mid_valid_q;
			ctrl.use_in_mid  = ~mid_valid_q;
			if (!mid_valid_q && s_tlast) begin
				// single-row frame: nothing held, result right away
				push      = 1'b1;
				push_last = 1'b1;
			end else begin
				push         = mid_valid_q;
				ctrl.advance = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_valid_q <= 1'b0;
			flush_q     <= 1'b0;
		end else if (flush_q) begin
			if (room) begin
				flush_q     <= 1'b0;
				mid_valid_q <= 1'b0;
			end
		end else if (in_beat) begin
			if (s_tlast) begin
				flush_q     <= mid_valid_q;
				mid_valid_q <= mid_valid_q;
			end else begin
				mid_valid_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Cell row: one cell per grid column, column sums passed sideways
	// ------------------------------------------------------------------
	logic [SUM_W-1:0] col_sum [GRID_COLS];
	logic [ROW_W-1:0] next_row;

	for (genvar k = 0; k < GRID_COLS; k++) begin : g_col
		logic [SUM_W-1:0] left_sum;
		logic [SUM_W-1:0] right_sum;

		if (k == 0) begin : g_left_edge
			assign left_sum = '0;
		end else begin : g_left
			assign left_sum = col_sum[k-1];
		end

		if (k == GRID_COLS - 1) begin : g_right_edge
			assign right_sum = '0;
		end else begin : g_right
			assign right_sum = col_sum[k+1];
		end

		lla_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.rule      (rule_q),
			.row_bit   (s_tdata[k]),
			.left_sum  (left_sum),
			.right_sum (right_sum),
			.col_sum   (col_sum[k]),
			.next_bit  (next_row[k])
		);
	end

	// columns past the grid stay dead
	for (genvar k = GRID_COLS; k < ROW_W; k++) begin : g_pad
		assign next_row[k] = 1'b0;
	end

	// ------------------------------------------------------------------
	// Result queue: two entries so input keeps moving while a beat waits
	// ------------------------------------------------------------------
	logic [BEAT_W-1:0] head;
	logic              fifo_not_empty;

	lla_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_last, next_row}),
		.pop       (m_tready),
		.not_full  (room),
		.not_empty (fifo_not_empty),
		.head      (head),
		.count     (fifo_count)
	);

	assign m_tvalid = fifo_not_empty;
	assign m_tdata  = head[ROW_W-1:0];
	assign m_tlast  = head[ROW_W];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fifo_bound : assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count != 2'd3)
		else $error("result queue count out of range");

	a_flush_blocks_input : assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !s_tready)
		else $error("input taken during flush");

	a_flush_follows_last : assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && s_tlast && mid_valid_q) |=> flush_q)
		else $error("final row of a multi-row frame did not start a flush");

	a_push_has_room : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("result pushed into a full queue");

endmodule

FILE: tb/tb_life_like_automaton_row_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_like_automaton_row_step
// Self-checking bench for the streamed life-like automaton row step.
// Grid frames go in one row per beat. A predictor keeps its own copy of the
// two held rows and of the birth/survive rules. It queues the next-generation
// rows that each accepted beat should release. A checker compares every
// result beat, row bits and frame_end flag, against the oldest queued row.
// Rule registers are rewritten over APB between frames, once the block has
// drained.
// ----------------------------------------------------------------------------
module tb_life_like_automaton_row_step;
	import lla_pkg::*;

	// register byte addresses, one 32-bit slot per rule
	localparam logic [2:0] BIRTH_ADDR   = {REG_BIRTH, 2'b00};
	localparam logic [2:0] SURVIVE_ADDR = {REG_SURVIVE, 2'b00};
	localparam int         DRAIN_CYCLES = 4;     // covers the flush step and the result queue
	localparam logic [ROW_W-1:0] ALL_ALIVE = {ROW_W{1'b1}};

	typedef struct packed {
		logic [ROW_W-1:0] cells;
		logic             frame_end;
	} row_result_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             psel     = 1'b0;
	logic             penable  = 1'b0;
	logic             pwrite   = 1'b0;
	logic [2:0]       paddr    = '0;
	logic [31:0]      pwdata   = '0;
	logic [31:0]      prdata;
	logic             pready;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [ROW_W-1:0] s_tdata  = '0;   // [63:0] row_cells
	logic             s_tlast  = 1'b0; // final_row
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [ROW_W-1:0] m_tdata;         // [63:0] next_row_cells
	logic             m_tlast;         // frame_end

	// predictor state: rules and the two rows held back for the neighbor count
	logic [3:0]       birth_rule     = BIRTH_RESET;
	logic [3:0]       survive_rule   = SURVIVE_RESET;
	logic [ROW_W-1:0] held_above     = '0;
	logic [ROW_W-1:0] held_middle    = '0;
	logic             middle_pending = 1'b0;
	row_result_t      pending_rows[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int rows_sent     = 0;
	int frames_sent   = 0;
	int rows_checked  = 0;
	int rule_settings = 1;

	life_like_automaton_row_step uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout: %0d result rows still owed", pending_rows.size());
		$display("tb_life_like_automaton_row_step: errors");
		$finish;
	end

	function automatic logic [ROW_W-1:0] grid_mask();
		logic [ROW_W-1:0] m;
		m = '0;
		for (int k = 0; k < GRID_COLS; k++) m[k] = 1'b1;
		return m;
	endfunction

	// One generation of the middle row. The rows are padded by a dead column
	// on each side, so column k sits at index k+1 of the padded vectors.
	function automatic logic [ROW_W-1:0] next_generation(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] down);
		logic [ROW_W+1:0] u;
		logic [ROW_W+1:0] m;
		logic [ROW_W+1:0] d;
		logic [ROW_W-1:0] nxt;
		int               live;
		u = {1'b0, up & grid_mask(), 1'b0};
		m = {1'b0, mid & grid_mask(), 1'b0};
		d = {1'b0, down & grid_mask(), 1'b0};
		for (int k = 0; k < ROW_W; k++) begin
			live = 0;
			for (int j = 0; j < 3; j++) begin
				live += u[k+j];
				live += d[k+j];
			end
			live += m[k];
			live += m[k+2];
			// birth wins over survive when both rules name the same count
			if (live == birth_rule) begin
				nxt[k] = 1'b1;
			end else if (live == survive_rule) begin
				nxt[k] = m[k+1];
			end else begin
				nxt[k] = 1'b0;
			end
		end
		return nxt & grid_mask();
	endfunction

	// Append one owed result row to the tail of the queue.
	task automatic queue_result(input logic [ROW_W-1:0] cells, input logic frame_end);
		row_result_t r;
		r.cells     = cells;
		r.frame_end = frame_end;
		pending_rows.insert(pending_rows.size(), r);
	endtask

	// Expected results for one accepted row beat.
	task automatic predict_row(input logic [ROW_W-1:0] cells, input logic last);
		logic [ROW_W-1:0] row;
		row = cells & grid_mask();
		rows_sent++;
		if (!middle_pending) begin
			// top row of a frame: held, unless it is also the bottom row
			if (last) begin
				queue_result(next_generation('0, row, '0), 1'b1);
			end else begin
				held_above     = '0;
				held_middle    = row;
				middle_pending = 1'b1;
			end
		end else begin
			queue_result(next_generation(held_above, held_middle, row), 1'b0);
			if (last) begin
				// flush: bottom row sees the dead border below it
				queue_result(next_generation(held_middle, row, '0), 1'b1);
				held_above     = '0;
				held_middle    = '0;
				middle_pending = 1'b0;
			end else begin
				held_above  = held_middle;
				held_middle = row;
			end
		end
		if (last) frames_sent++;
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		error_count++;
	endtask

	// Receiver: a fresh stall decision every cycle.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		row_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rows.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat %h last=%b", m_tdata, m_tlast));
			end else begin
				want = pending_rows.pop_front();
				if (m_tdata !== want.cells)
					report_mismatch($sformatf("row %0d: cells %h, want %h",
						rows_checked, m_tdata, want.cells));
				if (m_tlast !== want.frame_end)
					report_mismatch($sformatf("row %0d: frame_end %b, want %b",
						rows_checked, m_tlast, want.frame_end));
				rows_checked++;
			end
		end
	end

	// Send one row beat; the sender may idle first, with junk on the bus.
	// Called at a rising edge, returns at the edge that accepted the beat.
	task automatic send_row(input logic [ROW_W-1:0] cells, input logic last);
		int gap;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tlast  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cells;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_row(cells, last);
	endtask

	// Drop valid and let every owed row come out, plus the flush cycles.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup, then access; the register takes it on the access edge.
	// The bus then idles so that back-to-back writes start a fresh setup.
	task automatic write_rule(input logic [2:0] addr, input logic [3:0] value);
		logic [31:0] junk;
		junk = $urandom;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {junk[31:4], value};   // only the low nibble is held
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == BIRTH_ADDR) birth_rule = value;
		else survive_rule = value;
		@(posedge clk);
	endtask

	task automatic set_rules(input logic [3:0] birth, input logic [3:0] survive);
		wait_drained();
		write_rule(BIRTH_ADDR, birth);
		write_rule(SURVIVE_ADDR, survive);
		rule_settings++;
	endtask

	function automatic logic [ROW_W-1:0] random_row();
		logic [ROW_W-1:0] a;
		logic [ROW_W-1:0] b;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return a;
			1: return a & b & {$urandom, $urandom};   // sparse
			2: return a | b;                          // dense
			default: return ROW_W'($urandom_range(0, 255)) << $urandom_range(0, ROW_W - 8);
		endcase
	endfunction

	// Default rules: one-row frames, a blinker, edge columns, full rows.
	task automatic test_default_rules();
		send_row(ALL_ALIVE, 1'b1);                    // one-row frame, all alive
		send_row('0, 1'b1);                           // one-row frame, all dead
		send_row('0, 1'b0);                           // blinker turns vertical
		send_row(64'h0000_0000_0000_0038, 1'b0);
		send_row('0, 1'b1);
		send_row(64'h8000_0000_0000_0001, 1'b0);      // both edge columns
		send_row(64'hC000_0000_0000_0003, 1'b0);
		send_row(ALL_ALIVE, 1'b1);
		send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);      // two-row frame
		send_row(64'h5555_5555_5555_5555, 1'b1);
		send_row(ALL_ALIVE, 1'b1);
	endtask

	// Rule extremes: zero and eight neighbors, and counts no cell can reach.
	task automatic test_rule_extremes();
		logic [3:0] births[6]   = '{4'd0, 4'd8, 4'd15, 4'd0, 4'd8, 4'd9};
		logic [3:0] survives[6] = '{4'd0, 4'd8, 4'd15, 4'd8, 4'd0, 4'd3};
		for (int i = 0; i < 6; i++) begin
			set_rules(births[i], survives[i]);
			// interior cells of the top row see all five of their neighbors alive
			send_row(ALL_ALIVE, 1'b0);
			send_row(ALL_ALIVE, 1'b0);
			send_row(random_row(), 1'b1);
		end
	endtask

	// Random frames, mostly short, now and then tall; rules change between
	// frames while the block is idle.
	task automatic test_random_frames(input int n_rows, input int tx_idle, input int rx_idle);
		int sent;
		int height;
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		sent = 0;
		while (sent < n_rows) begin
			if ($urandom_range(0, 5) == 0 || sent == 0)
				set_rules(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 5)),
					($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(1, 5)));
			case ($urandom_range(0, 9))
				0: height = 1;
				1: height = 2;
				2: height = $urandom_range(20, 64);
				default: height = $urandom_range(3, 10);
			endcase
			if (height > n_rows - sent) height = n_rows - sent;
			for (int r = 0; r < height; r++) send_row(random_row(), r == height - 1);
			sent += height;
		end
		wait_drained();
	endtask

	initial begin
		send_idle_pct = 34;
		recv_idle_pct = 77;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_rules();
		test_rule_extremes();
		test_random_frames(340, 34, 77);
		test_random_frames(340, 77, 34);
		test_random_frames(340, 0, 0);

		repeat (8) @(posedge clk);
		$display("covered %0d rows in %0d frames under %0d rule settings;",
			rows_sent, frames_sent, rule_settings);
		$display("%0d result rows compared, %0d mismatches", rows_checked, error_count);
		if (error_count == 0 && pending_rows.size() == 0) begin
			$display("tb_life_like_automaton_row_step: clean");
		end else begin
			$display("tb_life_like_automaton_row_step: errors");
		end
		$finish;
	end

endmodule
